>>> hw/rtl/hpc_pkg.sv
// Package for the host text private classifier: word types, the scanner view,
// character codes, the loopback spelling table and small helper functions.
// No dependencies; every module of the block imports it.
`default_nettype none

package hpc_pkg;

  // One character of host text, with the end-of-text marker.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_word_t;

  // One classification result.
  typedef struct packed {
    logic       is_private;
    logic       is_loopback;
    logic       is_ipv4;
    logic [7:0] octet_a;
    logic [7:0] octet_b;
    logic [7:0] octet_c;
    logic [7:0] octet_d;
  } out_word_t;

  localparam int unsigned LitCount = 4;

  // Scanner state as it stands once the current character is folded in.
  typedef struct packed {
    logic [LitCount-1:0] lit_match;
    logic [3:0]          char_count;
    logic                quad_ok;
    logic [1:0]          octet_slot;
    logic [1:0]          digit_run;
    logic [9:0]          octet_accum;
    logic [2:0][7:0]     octet_store;
    logic [3:0][7:0]     head_chars;
  } view_t;

  // Literal indexes.
  localparam logic [1:0] LIT_DOTTED = 2'd0;
  localparam logic [1:0] LIT_NAME   = 2'd1;
  localparam logic [1:0] LIT_V6     = 2'd2;
  localparam logic [1:0] LIT_V6_BRK = 2'd3;

  // Loopback spellings, first character at index 0, zero padded.
  localparam logic [0:8][7:0] LIT_TEXT [LitCount] = '{
    "127.0.0.1",
    "localhost",
    {"::1", 48'h0},
    {"[::1]", 32'h0}
  };
  localparam logic [3:0] LIT_LEN [LitCount] = '{4'd9, 4'd9, 4'd3, 4'd5};

  localparam logic [3:0] COUNT_MAX = 4'd15;

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_C  = 8'h63;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_EIGHT = 8'h38;

  // Octet values of the private IPv4 ranges.
  localparam logic [7:0] OCT_127 = 8'd127;
  localparam logic [7:0] OCT_10  = 8'd10;
  localparam logic [7:0] OCT_172 = 8'd172;
  localparam logic [7:0] OCT_16  = 8'd16;
  localparam logic [7:0] OCT_31  = 8'd31;
  localparam logic [7:0] OCT_192 = 8'd192;
  localparam logic [7:0] OCT_168 = 8'd168;
  localparam logic [7:0] OCT_169 = 8'd169;
  localparam logic [7:0] OCT_254 = 8'd254;
  localparam logic [9:0] OCT_MAX = 10'd255;

  // Character of a loopback spelling at a position; positions past the
  // table read the first character and are masked by the length check.
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [3:0] pos);
    logic [3:0] idx;
    idx = (pos < 4'd9) ? pos : 4'd0;
    return LIT_TEXT[k][idx];
  endfunction

  // ASCII lowercase of A to Z, other bytes unchanged.
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) ? (c | 8'h20) : c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hpc_scan.sv
// Character scanner: running dotted-quad parse, literal match flags, length
// count and leading characters. Depends on hpc_pkg.
`default_nettype none

module hpc_scan (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire hpc_pkg::in_word_t word_i,
  output hpc_pkg::view_t       view_o
);
  import hpc_pkg::*;

  logic [1:0]          slot_q, slot_d;
  logic [1:0]          run_q, run_d;
  logic [9:0]          accum_q, accum_d;
  logic [2:0][7:0]     store_q, store_d;
  logic                quad_q, quad_d;
  logic [3:0]          count_q, count_d;
  logic [3:0][7:0]     head_q, head_d;
  logic [LitCount-1:0] lit_q, lit_d;

  logic                is_digit;
  logic [3:0]          digit;
  logic [13:0]         times_ten;

  assign is_digit  = (word_i.ch >= CH_ZERO) && (word_i.ch <= CH_NINE);
  assign digit     = 4'(word_i.ch - CH_ZERO);
  assign times_ten = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0};

  always_comb begin
    slot_d  = slot_q;
    run_d   = run_q;
    accum_d = accum_q;
    store_d = store_q;
    quad_d  = quad_q;

    if (quad_q) begin
      if (is_digit) begin
        if (run_q == 2'd3) begin
          quad_d = 1'b0;
        end else begin
          // At most two digits precede, so the value stays below 1000.
          accum_d = times_ten[9:0] + {6'b0, digit};
          run_d   = run_q + 2'd1;
        end
      end else if (word_i.ch == CH_DOT) begin
        if (run_q == 2'd0 || slot_q == 2'd3 || accum_q > OCT_MAX) begin
          quad_d = 1'b0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (slot_q == 2'(i)) begin
              store_d[i] = accum_q[7:0];
            end
          end
          slot_d  = slot_q + 2'd1;
          accum_d = '0;
          run_d   = '0;
        end
      end else begin
        quad_d = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      head_d[i] = (count_q == 4'(i)) ? word_i.ch : head_q[i];
    end
    for (int k = 0; k < LitCount; k++) begin
      lit_d[k] = lit_q[k] && (count_q < LIT_LEN[k]) &&
                 (lit_char(2'(k), count_q) == word_i.ch);
    end
    count_d = (count_q == COUNT_MAX) ? count_q : count_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      run_q   <= '0;
      accum_q <= '0;
      store_q <= '0;
      quad_q  <= 1'b1;
      count_q <= '0;
      head_q  <= '0;
      lit_q   <= '1;
    end else if (take_i) begin
      if (word_i.last) begin
        slot_q  <= '0;
        run_q   <= '0;
        accum_q <= '0;
        store_q <= '0;
        quad_q  <= 1'b1;
        count_q <= '0;
        head_q  <= '0;
        lit_q   <= '1;
      end else begin
        slot_q  <= slot_d;
        run_q   <= run_d;
        accum_q <= accum_d;
        store_q <= store_d;
        quad_q  <= quad_d;
        count_q <= count_d;
        head_q  <= head_d;
        lit_q   <= lit_d;
      end
    end
  end

  always_comb begin
    view_o.lit_match   = lit_d;
    view_o.char_count  = count_d;
    view_o.quad_ok     = quad_d;
    view_o.octet_slot  = slot_d;
    view_o.digit_run   = run_d;
    view_o.octet_accum = accum_d;
    view_o.octet_store = store_d;
    view_o.head_chars  = head_d;
  end

  // The end of a text returns the scanner to its starting state.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && word_i.last |=> count_q == 4'd0 && quad_q && lit_q == '1 && run_q == 2'd0)
    else $error("scanner did not restart after the last character");

  // The running octet never exceeds three decimal digits.
  a_accum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accum_q <= 10'd999)
    else $error("octet accumulator out of range");

  // A broken quad never recovers within one text.
  a_quad_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !quad_q && take_i && !word_i.last |=> !quad_q)
    else $error("dotted-quad flag came back within a text");

endmodule

`default_nettype wire

>>> hw/rtl/host_text_private_classifier_top.sv
// Top level of the host text private classifier: valid/ready ports, the
// result classification and the output register. Depends on hpc_pkg, hpc_scan.
//
//   Channel | Direction | Handshake               | Word
//   --------+-----------+-------------------------+--------------------------
//   in      | input     | in_valid_i / in_ready_o | in_word_i  (ch, last)
//   out     | output    | out_valid_o/out_ready_i | out_word_o (flags, octets)
//
// One character is taken per clock while the input is not stalled. A result
// appears in the output register the cycle after the character marked last
// is accepted. The input stalls only while a result sits in the output
// register and the output is not ready; a result can be taken and a new
// character accepted in the same cycle.
// Reset clears the scanner to the start of a new text and empties the output.
`default_nettype none

module host_text_private_classifier_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire hpc_pkg::in_word_t in_word_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output hpc_pkg::out_word_t out_word_o
);
  import hpc_pkg::*;

  logic                take;
  view_t               view;
  logic [LitCount-1:0] lit_hit;
  logic                loop_hit;
  logic                quad_hit;
  logic                v4_priv;
  logic                v6_priv;
  logic                bracketed;
  logic [3:0]          inner_len;
  logic [7:0]          c0, c1, c2;
  out_word_t           res_d;
  out_word_t           out_q;
  logic                out_valid_q, out_valid_d;

  // The output register frees up in the same cycle its word is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  hpc_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .word_i (in_word_i),
    .view_o (view)
  );

  always_comb begin
    // An exact spelling needs the match to survive and the length to agree.
    for (int k = 0; k < LitCount; k++) begin
      lit_hit[k] = view.lit_match[k] && (view.char_count == LIT_LEN[k]);
    end
    loop_hit = lit_hit[LIT_DOTTED] || lit_hit[LIT_NAME] || lit_hit[LIT_V6];

    // A quad is complete when the fourth octet holds one to three digits.
    quad_hit = view.quad_ok && (view.octet_slot == 2'd3) && (view.digit_run != 2'd0) &&
               (view.octet_accum <= OCT_MAX);

    v4_priv = (view.octet_store[0] == OCT_127) || (view.octet_store[0] == OCT_10) ||
              (view.octet_store[0] == OCT_172 && view.octet_store[1] >= OCT_16 &&
               view.octet_store[1] <= OCT_31) ||
              (view.octet_store[0] == OCT_192 && view.octet_store[1] == OCT_168) ||
              (view.octet_store[0] == OCT_169 && view.octet_store[1] == OCT_254);

    // One enclosing bracket pair is stripped before the prefix test. The
    // closing bracket is the character arriving now.
    bracketed = (view.char_count >= 4'd2) && (view.head_chars[0] == CH_LBRK) &&
                (in_word_i.ch == CH_RBRK);
    inner_len = bracketed ? view.char_count - 4'd2 : view.char_count;
    c0 = to_lower(bracketed ? view.head_chars[1] : view.head_chars[0]);
    c1 = to_lower(bracketed ? view.head_chars[2] : view.head_chars[1]);
    c2 = to_lower(bracketed ? view.head_chars[3] : view.head_chars[2]);

    // [::1] counts; else only the leading characters: fc, fd, or fe8 through feb.
    v6_priv = lit_hit[LIT_V6_BRK] ||
              (inner_len >= 4'd2 && c0 == CH_LO_F && (c1 == CH_LO_C || c1 == CH_LO_D)) ||
              (inner_len >= 4'd3 && c0 == CH_LO_F && c1 == CH_LO_E &&
               ((c2 == CH_EIGHT) || (c2 == CH_NINE) || (c2 == CH_LO_A) || (c2 == CH_LO_B)));

    res_d.is_loopback = loop_hit;
    res_d.is_ipv4     = quad_hit;
    // Loopback wins, then a valid quad decides alone, then the prefix test.
    res_d.is_private  = loop_hit || (quad_hit ? v4_priv : v6_priv);
    res_d.octet_a     = quad_hit ? view.octet_store[0]    : 8'd0;
    res_d.octet_b     = quad_hit ? view.octet_store[1]    : 8'd0;
    res_d.octet_c     = quad_hit ? view.octet_store[2]    : 8'd0;
    res_d.octet_d     = quad_hit ? view.octet_accum[7:0]  : 8'd0;
  end

  always_comb begin
    if (take && in_word_i.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_word_i.last) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // A stalled result blocks the input, so no result can be overwritten.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while a result is stalled");

  // Loopback spellings are always private.
  a_loop_priv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_loopback |-> out_q.is_private)
    else $error("loopback result not marked private");

  // Octets are zero unless the text is a valid quad.
  a_octets_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.is_ipv4 |->
      out_q.octet_a == 8'd0 && out_q.octet_b == 8'd0 &&
      out_q.octet_c == 8'd0 && out_q.octet_d == 8'd0)
    else $error("octets set without a valid quad");

endmodule

`default_nettype wire
